// ===== design/vdi_pkg.sv =====
`timescale 1ns / 1ps

package vdi_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int KEY_W        = 256;
  localparam int VIDX_W       = 10;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int SLOTS        = (MAX_VERTICES < 32) ? (1 << $clog2(MAX_VERTICES)) : 32;
  localparam int CELLS        = (MAX_VERTICES + SLOTS - 1) / SLOTS;
  localparam int WAIT_W       = $clog2(CELLS + 1);

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [VIDX_W-1:0] vidx_t;
  typedef logic [WAIT_W-1:0] wait_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic        mesh_end;
  } vtx_t;

  typedef struct packed {
    vidx_t vertex_index;
    logic  is_new;
    logic  overflow;
    logic  mesh_done;
  } res_t;

  typedef struct packed {
    key_t key;
    cnt_t count;
    logic wr_en;
  } bcast_t;

  typedef struct packed {
    logic hit;
    idx_t idx;
  } chain_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESOLVE
  } state_t;

endpackage

// ===== design/vdi_cell.sv =====
`timescale 1ns / 1ps

module vdi_cell (
  input  logic            clk,
  input  vdi_pkg::bcast_t bcast,
  input  vdi_pkg::idx_t   base,
  input  vdi_pkg::chain_t prev,
  output vdi_pkg::chain_t next
);

  vdi_pkg::key_t   keys [vdi_pkg::SLOTS];
  vdi_pkg::idx_t   slot_idx [vdi_pkg::SLOTS];
  logic            loc_hit_next;
  vdi_pkg::idx_t   loc_idx_next;
  logic            loc_hit;
  vdi_pkg::idx_t   loc_idx;

  always_comb begin
    loc_hit_next = 1'b0;
    loc_idx_next = '0;
    for (int k = 0; k < vdi_pkg::SLOTS; k++) begin
      slot_idx[k] = base | vdi_pkg::idx_t'(k);
      if ((vdi_pkg::cnt_t'(slot_idx[k]) < bcast.count) && (keys[k] == bcast.key)) begin
        loc_hit_next = 1'b1;
        loc_idx_next = loc_idx_next | slot_idx[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < vdi_pkg::SLOTS; k++) begin
      if (bcast.wr_en && (vdi_pkg::cnt_t'(slot_idx[k]) == bcast.count)) begin
        keys[k] <= bcast.key;
      end
    end
  end

  // stored keys are distinct, so at most one hit along the chain
  always_ff @(posedge clk) begin
    loc_hit  <= loc_hit_next;
    loc_idx  <= loc_idx_next;
    next.hit <= loc_hit | prev.hit;
    next.idx <= loc_hit ? loc_idx : prev.idx;
  end

endmodule

// ===== design/vdi_ctrl.sv =====
`timescale 1ns / 1ps

module vdi_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            vtx_valid,
  output logic            vtx_ready,
  input  vdi_pkg::vtx_t   vtx,
  output logic            res_valid,
  input  logic            res_ready,
  output vdi_pkg::res_t   res,
  output vdi_pkg::bcast_t bcast,
  input  vdi_pkg::chain_t chain_end
);

  vdi_pkg::state_t state;
  vdi_pkg::state_t state_next;
  vdi_pkg::wait_t  wait_cnt;
  vdi_pkg::key_t   key;
  logic            last;
  vdi_pkg::cnt_t   count;
  vdi_pkg::cnt_t   count_next;
  vdi_pkg::res_t   res_next;
  logic            out_free;
  logic            res_load;
  logic            room;
  logic            wr_en;

  assign out_free = !res_valid || res_ready;
  assign room     = count < vdi_pkg::cnt_t'(vdi_pkg::MAX_VERTICES);

  always_comb begin
    state_next = state;
    unique case (state)
      vdi_pkg::S_IDLE: begin
        if (vtx_valid) state_next = vdi_pkg::S_SEARCH;
      end
      vdi_pkg::S_SEARCH: begin
        if (wait_cnt == vdi_pkg::wait_t'(vdi_pkg::CELLS)) state_next = vdi_pkg::S_RESOLVE;
      end
      vdi_pkg::S_RESOLVE: begin
        if (out_free) state_next = vdi_pkg::S_IDLE;
      end
      default: state_next = vdi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    vtx_ready = (state == vdi_pkg::S_IDLE);
    res_load  = (state == vdi_pkg::S_RESOLVE) && out_free;
    wr_en     = res_load && !chain_end.hit && room;
    res_next.mesh_done = last;
    priority if (chain_end.hit) begin
      res_next.vertex_index = vdi_pkg::vidx_t'(chain_end.idx);
      res_next.is_new       = 1'b0;
      res_next.overflow     = 1'b0;
    end else if (room) begin
      res_next.vertex_index = vdi_pkg::vidx_t'(vdi_pkg::idx_t'(count));
      res_next.is_new       = 1'b1;
      res_next.overflow     = 1'b0;
    end else begin
      res_next.vertex_index = '0;
      res_next.is_new       = 1'b0;
      res_next.overflow     = 1'b1;
    end
    if (last) begin
      count_next = '0;
    end else if (res_next.is_new) begin
      count_next = count + 1'b1;
    end else begin
      count_next = count;
    end
    bcast.key   = key;
    bcast.count = count;
    bcast.wr_en = wr_en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vdi_pkg::S_IDLE;
      wait_cnt  <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      wait_cnt <= (state == vdi_pkg::S_SEARCH) ? wait_cnt + 1'b1 : '0;
      if (res_load) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vtx_valid && vtx_ready) begin
      key  <= {vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.norm_x,
               vtx.norm_y, vtx.norm_z, vtx.tex_u, vtx.tex_v};
      last <= vtx.mesh_end;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= vdi_pkg::cnt_t'(vdi_pkg::MAX_VERTICES))
    else $error("vertex count beyond table size");

  a_mesh_clear: assert property (@(posedge clk) disable iff (rst)
    res_load && last |=> count == '0)
    else $error("table not cleared after mesh end");

  a_insert_step: assert property (@(posedge clk) disable iff (rst)
    wr_en && !last |=> count == $past(count) + 1'b1)
    else $error("insert did not advance count");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.is_new && res.overflow))
    else $error("new and overflow together");

endmodule

// ===== design/vertex_dedup_indexer_top.sv =====
`timescale 1ns / 1ps
// Each accepted item is searched by the registered match chain running through the cells
// of SLOTS stored vertices each; a new item is taken only after the previous result has
// been loaded into the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous): clears control and the vertex count; stored keys are not
// cleared, entries at or above the count are never compared.

module vertex_dedup_indexer_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          vtx_valid,
  output logic          vtx_ready,
  input  vdi_pkg::vtx_t vtx,
  output logic          res_valid,
  input  logic          res_ready,
  output vdi_pkg::res_t res
);

  vdi_pkg::bcast_t bcast;
  vdi_pkg::chain_t link [vdi_pkg::CELLS + 1];

  assign link[0] = '0;

  for (genvar c = 0; c < vdi_pkg::CELLS; c++) begin : g_cell
    vdi_cell u_cell (
      .clk   (clk),
      .bcast (bcast),
      .base  (vdi_pkg::idx_t'(c * vdi_pkg::SLOTS)),
      .prev  (link[c]),
      .next  (link[c+1])
    );
  end

  vdi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .bcast     (bcast),
    .chain_end (link[vdi_pkg::CELLS])
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int PHASE_LEN   = 150;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 60;
  localparam int STALL_LIMIT = 3000;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          vtx_valid = 1'b0;
  logic          vtx_ready;
  vdi_pkg::vtx_t vtx       = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  vdi_pkg::res_t res;

  vertex_dedup_indexer_top dut (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vdi_pkg::vtx_t vtx_backlog[$];
  vdi_pkg::res_t res_due[$];
  vdi_pkg::key_t known_keys[vdi_pkg::MAX_VERTICES];
  int unsigned   known_count    = 0;
  int unsigned   total_items    = 0;
  int unsigned   sent_total     = 0;
  int unsigned   checked_total  = 0;
  int unsigned   overflow_total = 0;
  int unsigned   mesh_total     = 0;
  int unsigned   err_count      = 0;
  int unsigned   quiet_cycles   = 0;
  int unsigned   hold_cnt       = 0;
  logic          in_taken       = 1'b0;
  logic          hold_active    = 1'b0;
  logic          hold_done      = 1'b0;

  // table lookup with append; the table empties after a mesh_end item
  function automatic vdi_pkg::res_t dedup_lookup(vdi_pkg::vtx_t v);
    vdi_pkg::key_t k;
    vdi_pkg::res_t r;
    bit            hit;
    int unsigned   i;
    k   = {v.pos_x, v.pos_y, v.pos_z, v.norm_x, v.norm_y, v.norm_z, v.tex_u, v.tex_v};
    r   = '0;
    hit = 1'b0;
    for (i = 0; i < known_count && !hit; i++) begin
      if (known_keys[i] == k) begin
        hit            = 1'b1;
        r.vertex_index = vdi_pkg::vidx_t'(i);
      end
    end
    if (!hit) begin
      if (known_count < vdi_pkg::MAX_VERTICES) begin
        known_keys[known_count] = k;
        r.vertex_index          = vdi_pkg::vidx_t'(known_count);
        r.is_new                = 1'b1;
        known_count++;
      end else begin
        r.overflow = 1'b1;
      end
    end
    r.mesh_done = v.mesh_end;
    if (v.mesh_end) known_count = 0;
    return r;
  endfunction

  function automatic logic [31:0] float_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h7fc0_0000 | ($urandom & 32'h003f_ffff);
      4: return 32'h3f80_0000;
      5: return 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic vdi_pkg::vtx_t rand_vertex();
    vdi_pkg::vtx_t v;
    v.pos_x    = float_word();
    v.pos_y    = float_word();
    v.pos_z    = float_word();
    v.norm_x   = float_word();
    v.norm_y   = float_word();
    v.norm_z   = float_word();
    v.tex_u    = float_word();
    v.tex_v    = float_word();
    v.mesh_end = 1'b0;
    return v;
  endfunction

  function automatic vdi_pkg::vtx_t make_vtx(logic [31:0] fill, logic last);
    return {fill, fill, fill, fill, fill, fill, fill, fill, last};
  endfunction

  task automatic stash_vtx(vdi_pkg::vtx_t v);
    vtx_backlog = {vtx_backlog, v};
  endtask

  task automatic add_directed();
    vdi_pkg::vtx_t v;
    stash_vtx(make_vtx(32'h0000_0000, 1'b0));
    stash_vtx(make_vtx(32'hffff_ffff, 1'b0));
    stash_vtx(make_vtx(32'h0000_0000, 1'b0));
    // signed zero differs from zero
    v = make_vtx(32'h0000_0000, 1'b0);
    v.pos_x = 32'h8000_0000;
    stash_vtx(v);
    v = make_vtx(32'h0000_0000, 1'b0);
    v.tex_v = 32'h8000_0000;
    stash_vtx(v);
    v = make_vtx(32'h0000_0000, 1'b0);
    v.pos_x = 32'h0000_0001;
    stash_vtx(v);
    v = make_vtx(32'h0000_0000, 1'b0);
    v.norm_x = 32'h0000_0001;
    stash_vtx(v);
    // NaN patterns match only themselves
    stash_vtx(make_vtx(32'h7fc0_0000, 1'b0));
    stash_vtx(make_vtx(32'h7fc0_0001, 1'b0));
    stash_vtx(make_vtx(32'h7fc0_0000, 1'b0));
    v = make_vtx(32'hffff_ffff, 1'b0);
    v.norm_y = 32'h7fff_ffff;
    stash_vtx(v);
    stash_vtx(make_vtx(32'haaaa_aaaa, 1'b0));
    stash_vtx(make_vtx(32'h5555_5555, 1'b0));
    // mesh end on a known vertex, then fresh mesh
    stash_vtx(make_vtx(32'hffff_ffff, 1'b1));
    stash_vtx(make_vtx(32'hffff_ffff, 1'b0));
    stash_vtx(make_vtx(32'h0000_0000, 1'b1));
    // single vertex meshes back to back
    stash_vtx(make_vtx(32'h0000_0000, 1'b1));
    stash_vtx(make_vtx(32'h0000_0000, 1'b1));
    stash_vtx(make_vtx(32'h5555_5555, 1'b0));
  endtask

  task automatic add_random_meshes(int unsigned n_items);
    vdi_pkg::vtx_t pool[$];
    vdi_pkg::vtx_t prev_pool[$];
    vdi_pkg::vtx_t v;
    int unsigned   added;
    int unsigned   len;
    int unsigned   n_pool;
    int unsigned   j;
    added = 0;
    while (added < n_items) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      if (len > n_items - added) len = n_items - added;
      n_pool = $urandom_range(1, 10);
      pool   = {};
      for (j = 0; j < n_pool; j++) begin
        if (prev_pool.size() != 0 && $urandom_range(0, 3) == 0)
          pool = {pool, prev_pool[$urandom_range(0, prev_pool.size() - 1)]};
        else
          pool = {pool, rand_vertex()};
      end
      for (j = 0; j < len; j++) begin
        case ($urandom_range(0, 9))
          0: v = rand_vertex();
          1: v = (prev_pool.size() != 0) ? prev_pool[$urandom_range(0, prev_pool.size() - 1)]
                                         : rand_vertex();
          default: v = pool[$urandom_range(0, pool.size() - 1)];
        endcase
        // occasional early end breaks the mesh
        v.mesh_end = (j == len - 1) || ($urandom_range(0, 49) == 0);
        stash_vtx(v);
        added++;
      end
      prev_pool = pool;
    end
  endtask

  task automatic add_full_mesh();
    vdi_pkg::vtx_t v;
    vdi_pkg::vtx_t first_v;
    vdi_pkg::vtx_t last_v;
    logic [31:0]   tag;
    int unsigned   i;
    tag = $urandom;
    for (i = 0; i < vdi_pkg::MAX_VERTICES; i++) begin
      v       = rand_vertex();
      v.pos_x = tag ^ i;
      if (i == 0) first_v = v;
      last_v = v;
      stash_vtx(v);
      if (i % 97 == 5) stash_vtx(first_v);
    end
    v       = rand_vertex();
    v.pos_x = tag ^ 32'hffff_0000;
    stash_vtx(v);
    stash_vtx(last_v);
    stash_vtx(first_v);
    v.pos_x = tag ^ 32'h0001_0000;
    stash_vtx(v);
    // overflowing vertex closes the mesh
    v.pos_x    = tag ^ 32'h0002_0000;
    v.mesh_end = 1'b1;
    stash_vtx(v);
    stash_vtx(first_v);
    last_v.mesh_end = 1'b1;
    stash_vtx(last_v);
  endtask

  always @(negedge clk) begin : drive
    int unsigned ph;
    int unsigned pct;
    ph  = (sent_total / PHASE_LEN) % 4;
    pct = (ph == 1) ? 81 : (ph == 3) ? 28 : 0;
    if (!rst && (!vtx_valid || in_taken)) begin
      if (vtx_backlog.size() != 0 && $urandom_range(0, 99) >= pct) begin
        vtx       <= vtx_backlog.pop_front();
        vtx_valid <= 1'b1;
      end else begin
        vtx_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : sink
    int unsigned ph;
    int unsigned pct;
    ph  = (sent_total / PHASE_LEN) % 4;
    pct = (ph == 2) ? 81 : (ph == 3) ? 28 : 0;
    res_ready <= !hold_active && ($urandom_range(0, 99) >= pct);
  end

  // one long receiver hold-off so the input side backs up
  always @(negedge clk) begin
    if (hold_active) begin
      if (hold_cnt == HOLD_CYCLES - 1) begin
        hold_active <= 1'b0;
        hold_done   <= 1'b1;
      end
      hold_cnt <= hold_cnt + 1;
    end else if (!hold_done && sent_total >= HOLD_AT) begin
      hold_active <= 1'b1;
      hold_cnt    <= 0;
    end
  end

  always @(posedge clk) begin : track
    vdi_pkg::res_t want;
    in_taken <= vtx_valid && vtx_ready;
    if (!rst && vtx_valid && vtx_ready) begin
      res_due = {res_due, dedup_lookup(vtx)};
      sent_total <= sent_total + 1;
    end
    if (!rst && res_valid && res_ready) begin
      checked_total <= checked_total + 1;
      if (res_due.size() == 0) begin
        $display("%0t: unexpected result idx=%0d new=%0b ovf=%0b done=%0b", $time,
                 res.vertex_index, res.is_new, res.overflow, res.mesh_done);
        err_count++;
      end else begin
        want = res_due.pop_front();
        if (res !== want) begin
          $display("%0t: mismatch expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                   $time, want.vertex_index, want.is_new, want.overflow, want.mesh_done,
                   res.vertex_index, res.is_new, res.overflow, res.mesh_done);
          err_count++;
        end
        if (want.overflow) overflow_total <= overflow_total + 1;
        if (want.mesh_done) mesh_total <= mesh_total + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (vtx_valid && vtx_ready) || (res_valid && res_ready) ||
        (sent_total == total_items && res_due.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    add_directed();
    add_random_meshes(20);
    add_full_mesh();
    add_random_meshes(20);
    total_items = vtx_backlog.size();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (sent_total != total_items || res_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (res_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, res_due.size());
      err_count++;
    end
    $display("tb_top: %0d vertices, %0d results checked, %0d meshes closed, %0d overflows",
             sent_total, checked_total, mesh_total, overflow_total);
    $display("tb_top: idle mixes rotated every %0d items, one %0d-cycle output hold-off",
             PHASE_LEN, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/vdi_pkg.sv
design/vdi_cell.sv
design/vdi_ctrl.sv
design/vertex_dedup_indexer_top.sv
verif/tb_top.sv
